@@ rtl/chip8_instruction_execute_macros.svh @@
// Assertion macros for the CHIP-8 execute block.
`ifndef CHIP8_INSTRUCTION_EXECUTE_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTE_MACROS_SVH
`ifndef SYNTHESIS
`define C8_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define C8_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define C8_ASSERT_IMP(label, clk, rst, a, c)
`define C8_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

@@ rtl/c8x_pkg.sv @@
// Shared types and constants for the CHIP-8 execute block.
package c8x_pkg;
   localparam int MEM_BYTES = 4096;
   localparam int SCREEN_W = 64;
   localparam int SCREEN_H = 32;
   localparam int STACK_DEPTH = 16;
   localparam int KEYS = 16;

   localparam logic [1:0] REQ_EXEC = 2'd0;
   localparam logic [1:0] REQ_WMEM = 2'd1;
   localparam logic [1:0] REQ_ROW = 2'd2;
   localparam logic [1:0] REQ_SETPC = 2'd3;

   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;
endpackage

@@ rtl/c8x_ram.sv @@
// Generic single-port-write, registered-read RAM.
module c8x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/chip8_instruction_execute.sv @@
// CHIP-8 execute block: one request per start pulse, result strobed on rsp_valid.
// Most requests complete from S_DEC; 00EE passes S_RET, a row read S_ROW, a screen
// clear S_CLEAR, Dxyn (n > 0) alternates S_SPR_R/S_SPR_W per sprite row, Fx33 S_BCD,
// Fx55 S_SAVE and Fx65 S_LOAD; a new request is taken while the result is strobed.
// Each memory port serves one access per cycle. Reset clears the architectural
// registers and busy stays high for a clearing pass over the frame memory. No rx stall.
`include "chip8_instruction_execute_macros.svh"
module chip8_instruction_execute #(
   parameter int STACK_DEPTH = c8x_pkg::STACK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_opcode,
   input  logic [15:0] req_key_mask,
   input  logic [7:0]  req_random_byte,
   input  logic [11:0] req_mem_address,
   input  logic [7:0]  req_mem_data,
   input  logic [4:0]  req_row_select,
   output logic        rsp_valid,
   output logic [11:0] rsp_pc_out,
   output logic [15:0] rsp_index_out,
   output logic        rsp_draw_request,
   output logic        rsp_bad_opcode,
   output logic [63:0] rsp_row_pixels
);
   localparam int SPW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [SPW-1:0] SP_LAST = SPW'(STACK_DEPTH - 1);

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_DEC   = 10'b0000000100,
      S_RET   = 10'b0000001000,
      S_SPR_R = 10'b0000010000,
      S_SPR_W = 10'b0000100000,
      S_BCD   = 10'b0001000000,
      S_SAVE  = 10'b0010000000,
      S_LOAD  = 10'b0100000000,
      S_ROW   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // architectural registers
   logic [7:0]  vregs_ff [16];
   logic [15:0] index_ff, index_in;
   logic [11:0] pc_ff, pc_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [7:0]  delay_ff, sound_ff;

   // request latch
   logic [1:0]  type_ff;
   logic [15:0] op_ff, keys_ff;
   logic [7:0]  rnd_ff, wdat_ff;
   logic [11:0] addr_ff;
   logic [4:0]  rsel_ff;

   // walk state
   logic [4:0]  cnt_ff, cnt_in;
   logic        hit_ff, hit_in;
   logic [7:0]  bits_ff;
   logic [5:0]  xp_ff;
   logic [4:0]  yp_ff;

   // response registers
   logic        rv_ff, rv_in;
   logic        draw_in, bad_in;
   logic        draw_ff, bad_ff;
   logic [63:0] row_ff, row_in;

   // memories
   logic        m_we;
   logic [11:0] m_wa, m_ra;
   logic [7:0]  m_wd, m_rd;
   logic        f_we;
   logic [4:0]  f_wa, f_ra;
   logic [63:0] f_wd, f_rd;
   logic        s_we;
   logic [SPW-1:0] s_wa, s_ra;
   logic [11:0] s_wd, s_rd;

   c8x_ram #(.WIDTH(8), .DEPTH(c8x_pkg::MEM_BYTES)) u_mem (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_addr(m_ra), .rd_data(m_rd));
   c8x_ram #(.WIDTH(64), .DEPTH(c8x_pkg::SCREEN_H)) u_frame (
      .clock(clock), .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_addr(f_ra), .rd_data(f_rd));
   c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd));

   // stack pointer steps, wrapping over the stack depth
   logic [SPW-1:0] sp_inc, sp_dec;
   assign sp_inc = (sp_ff == SP_LAST) ? '0 : sp_ff + SPW'(1);
   assign sp_dec = (sp_ff == '0) ? SP_LAST : sp_ff - SPW'(1);

   // opcode fields
   logic [3:0]  o_hi, o_x, o_y, o_n;
   logic [7:0]  o_nn, vx, vy;
   logic [11:0] o_nnn;
   assign o_hi = op_ff[15:12];
   assign o_x = op_ff[11:8];
   assign o_y = op_ff[7:4];
   assign o_n = op_ff[3:0];
   assign o_nn = op_ff[7:0];
   assign o_nnn = op_ff[11:0];
   assign vx = vregs_ff[o_x];
   assign vy = vregs_ff[o_y];

   // key decode
   logic       kdown;
   logic       kany;
   logic [3:0] klow;
   assign kdown = (vx < 8'(c8x_pkg::KEYS)) ? keys_ff[vx[3:0]] : 1'b0;
   assign kany = |keys_ff;
   always_comb begin
      klow = '0;
      for (int k = c8x_pkg::KEYS - 1; k >= 0; k--) begin
         if (keys_ff[k]) begin
            klow = 4'(k);
         end
      end
   end

   // ALU for 8xyN
   logic [8:0] add9;
   assign add9 = {1'b0, vx} + {1'b0, vy};

   // BCD digits of vx
   logic [7:0] hund, tens, ones, rem1;
   always_comb begin
      hund = (vx >= 8'd200) ? 8'd2 : ((vx >= 8'd100) ? 8'd1 : 8'd0);
      rem1 = vx - 8'(hund * 8'd100);
      tens = 8'((16'(rem1) * 16'd205) >> 11);
      ones = rem1 - 8'(tens * 8'd10);
   end

   // sprite shifted into row position (wraps over 64 columns)
   logic [127:0] spr_wide;
   logic [63:0]  spr_mask;
   assign spr_wide = {bits_ff, 120'd0} >> xp_ff;
   assign spr_mask = spr_wide[127:64] | spr_wide[63:0];

   logic        vwe;
   logic [3:0]  vwa;
   logic [7:0]  vwd;
   logic        fwe;
   logic [7:0]  fwd;
   logic [11:0] idx12;
   assign idx12 = index_ff[11:0];

   function automatic logic [7:0] req_and(input logic [7:0] a, input logic [7:0] b);
      return a & b;
   endfunction

   always_comb begin
      state_in = state_ff;
      index_in = index_ff;
      pc_in = pc_ff;
      sp_in = sp_ff;
      cnt_in = cnt_ff;
      hit_in = hit_ff;
      rv_in = 1'b0;
      draw_in = draw_ff;
      bad_in = bad_ff;
      row_in = row_ff;
      m_we = 1'b0;
      m_wa = idx12;
      m_wd = wdat_ff;
      m_ra = idx12;
      f_we = 1'b0;
      f_wa = cnt_ff;
      f_wd = '0;
      f_ra = rsel_ff;
      s_we = 1'b0;
      s_wa = sp_ff;
      s_wd = pc_ff;
      s_ra = sp_dec;
      vwe = 1'b0;
      vwa = o_x;
      vwd = '0;
      fwe = 1'b0;
      fwd = '0;
      case (state_ff)
         S_CLEAR: begin
            f_we = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = S_IDLE;
               if (type_ff == c8x_pkg::REQ_EXEC && draw_ff) begin
                  rv_in = 1'b1;
               end
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            draw_in = 1'b0;
            bad_in = 1'b0;
            row_in = '0;
            cnt_in = '0;
            hit_in = 1'b0;
            state_in = S_IDLE;
            rv_in = 1'b1;
            case (type_ff)
               c8x_pkg::REQ_WMEM: begin
                  m_we = 1'b1;
                  m_wa = addr_ff;
               end
               c8x_pkg::REQ_ROW: begin
                  state_in = S_ROW;
                  rv_in = 1'b0;
               end
               c8x_pkg::REQ_SETPC: begin
                  pc_in = addr_ff;
               end
               default: begin
                  case (o_hi)
                     4'h0: begin
                        if (op_ff == c8x_pkg::OP_CLS) begin
                           draw_in = 1'b1;
                           state_in = S_CLEAR;
                           rv_in = 1'b0;
                        end else if (op_ff == c8x_pkg::OP_RET) begin
                           sp_in = sp_dec;
                           state_in = S_RET;
                           rv_in = 1'b0;
                        end else begin
                           bad_in = 1'b1;
                        end
                     end
                     4'h1: pc_in = o_nnn;
                     4'h2: begin
                        s_we = 1'b1;
                        sp_in = sp_inc;
                        pc_in = o_nnn;
                     end
                     4'h3: if (vx == o_nn) pc_in = pc_ff + 12'd2;
                     4'h4: if (vx != o_nn) pc_in = pc_ff + 12'd2;
                     4'h5: if (vx == vy) pc_in = pc_ff + 12'd2;
                     4'h6: begin vwe = 1'b1; vwd = o_nn; end
                     4'h7: begin vwe = 1'b1; vwd = vx + o_nn; end
                     4'h8: begin
                        vwe = 1'b1;
                        fwe = 1'b1;
                        case (o_n)
                           4'h0: begin vwd = vy; fwe = 1'b0; end
                           4'h1: vwd = vx | vy;
                           4'h2: vwd = vx & vy;
                           4'h3: vwd = vx ^ vy;
                           4'h4: begin vwd = add9[7:0]; fwd = {7'd0, add9[8]}; end
                           4'h5: begin vwd = vx - vy; fwd = {7'd0, vx >= vy}; end
                           4'h6: begin vwd = {1'b0, vy[7:1]}; fwd = {7'd0, vy[0]}; end
                           4'h7: begin vwd = vy - vx; fwd = {7'd0, vy >= vx}; end
                           4'hE: begin vwd = {vy[6:0], 1'b0}; fwd = {7'd0, vy[7]}; end
                           default: begin vwe = 1'b0; fwe = 1'b0; bad_in = 1'b1; end
                        endcase
                     end
                     4'h9: if (vx != vy) pc_in = pc_ff + 12'd2;
                     4'hA: index_in = {4'd0, o_nnn};
                     4'hB: pc_in = o_nnn + {4'd0, vregs_ff[0]};
                     4'hC: begin vwe = 1'b1; vwd = req_and(rnd_ff, o_nn); end
                     4'hD: begin
                        draw_in = 1'b1;
                        if (o_n == 4'd0) begin
                           fwe = 1'b1;
                        end else begin
                           m_ra = idx12;
                           state_in = S_SPR_R;
                           rv_in = 1'b0;
                        end
                     end
                     4'hE: begin
                        if (o_nn == 8'h9E) begin
                           if (kdown) pc_in = pc_ff + 12'd2;
                        end else if (o_nn == 8'hA1) begin
                           if (!kdown) pc_in = pc_ff + 12'd2;
                        end else begin
                           bad_in = 1'b1;
                        end
                     end
                     default: begin
                        case (o_nn)
                           8'h07: begin vwe = 1'b1; vwd = delay_ff; end
                           8'h0A: begin
                              if (kany) begin
                                 vwe = 1'b1;
                                 vwd = {4'd0, klow};
                              end else begin
                                 pc_in = pc_ff - 12'd2;
                              end
                           end
                           8'h15, 8'h18: begin end
                           8'h1E: index_in = index_ff + {8'd0, vx};
                           8'h29: index_in = {8'd0, vx} * 16'd5;
                           8'h33: begin
                              m_we = 1'b1;
                              m_wd = hund;
                              state_in = S_BCD;
                              rv_in = 1'b0;
                           end
                           8'h55: begin
                              state_in = S_SAVE;
                              rv_in = 1'b0;
                           end
                           8'h65: begin
                              m_ra = idx12;
                              state_in = S_LOAD;
                              rv_in = 1'b0;
                           end
                           default: bad_in = 1'b1;
                        endcase
                     end
                  endcase
               end
            endcase
         end
         S_RET: begin
            pc_in = s_rd;
            state_in = S_IDLE;
            rv_in = 1'b1;
         end
         S_SPR_R: begin
            // sprite byte is on the read port; issue the read of its frame row
            f_ra = yp_ff + cnt_ff;
            m_ra = idx12 + 12'(cnt_ff);
            state_in = S_SPR_W;
         end
         S_SPR_W: begin
            f_we = 1'b1;
            f_wa = yp_ff + cnt_ff;
            f_wd = f_rd ^ spr_mask;
            m_ra = idx12 + 12'(cnt_ff) + 12'd1;
            hit_in = hit_ff | (|(f_rd & spr_mask));
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff + 5'd1 == {1'b0, o_n}) begin
               vwe = 1'b1;
               vwa = 4'hF;
               vwd = {7'd0, hit_ff | (|(f_rd & spr_mask))};
               state_in = S_IDLE;
               rv_in = 1'b1;
            end else begin
               state_in = S_SPR_R;
            end
         end
         S_BCD: begin
            m_we = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            m_wa = idx12 + 12'(cnt_ff) + 12'd1;
            m_wd = (cnt_ff == 5'd0) ? tens : ones;
            if (cnt_ff == 5'd1) begin
               state_in = S_IDLE;
               rv_in = 1'b1;
            end
         end
         S_SAVE: begin
            m_we = 1'b1;
            m_wa = idx12 + 12'(cnt_ff);
            m_wd = vregs_ff[cnt_ff[3:0]];
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff[3:0] == o_x) begin
               index_in = index_ff + {12'd0, o_x} + 16'd1;
               state_in = S_IDLE;
               rv_in = 1'b1;
            end
         end
         S_LOAD: begin
            // read byte cnt each cycle; from cnt_ff == 1 on, write register cnt-1
            m_ra = idx12 + 12'(cnt_ff);
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff != 5'd0) begin
               vwe = 1'b1;
               vwa = 4'(cnt_ff - 5'd1);
               vwd = m_rd;
               if (4'(cnt_ff - 5'd1) == o_x) begin
                  index_in = index_ff + {12'd0, o_x} + 16'd1;
                  state_in = S_IDLE;
                  rv_in = 1'b1;
               end
            end
         end
         S_ROW: begin
            row_in = f_rd;
            state_in = S_IDLE;
            rv_in = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         index_ff <= '0;
         pc_ff <= '0;
         sp_ff <= '0;
         delay_ff <= '0;
         sound_ff <= '0;
         cnt_ff <= '0;
         rv_ff <= 1'b0;
         draw_ff <= 1'b0;
         type_ff <= c8x_pkg::REQ_WMEM;
         for (int i = 0; i < 16; i++) begin
            vregs_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         index_ff <= index_in;
         pc_ff <= pc_in;
         sp_ff <= sp_in;
         cnt_ff <= cnt_in;
         rv_ff <= rv_in;
         draw_ff <= draw_in;
         // the flag write wins when the result register is VF
         if (vwe && !(fwe && vwa == 4'hF)) begin
            vregs_ff[vwa] <= vwd;
         end
         if (fwe) begin
            vregs_ff[15] <= fwd;
         end
         if (state_ff == S_DEC && type_ff == c8x_pkg::REQ_EXEC && o_hi == 4'hF) begin
            if (o_nn == 8'h15) delay_ff <= vx;
            if (o_nn == 8'h18) sound_ff <= vx;
         end
         if (start && !busy) begin
            type_ff <= req_type;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      bad_ff <= bad_in;
      row_ff <= row_in;
      if (state_ff == S_SPR_W || (state_ff == S_DEC && o_hi == 4'hD)) begin
         bits_ff <= m_rd;
      end
      if (state_ff == S_SPR_R) begin
         bits_ff <= m_rd;
      end
      if (state_ff == S_DEC) begin
         xp_ff <= vx[5:0];
         yp_ff <= vy[4:0];
      end
      if (start && !busy) begin
         op_ff <= req_opcode;
         keys_ff <= req_key_mask;
         rnd_ff <= req_random_byte;
         addr_ff <= req_mem_address;
         wdat_ff <= req_mem_data;
         rsel_ff <= req_row_select;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_pc_out = pc_ff;
   assign rsp_index_out = index_ff;
   assign rsp_draw_request = draw_ff;
   assign rsp_bad_opcode = bad_ff;
   assign rsp_row_pixels = row_ff;

   `C8_ASSERT_IMP(a_busy_rsp, clock, reset, rsp_valid, !$past(busy) == 1'b0)
   `C8_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `C8_ASSERT_IMP(a_row_zero, clock, reset, rsp_valid && rsp_row_pixels != 64'd0,
      type_ff == c8x_pkg::REQ_ROW)
   `C8_ASSERT_IMP(a_flags, clock, reset, rsp_valid, !(rsp_draw_request && rsp_bad_opcode))
endmodule
